### hdl/ptan_pkg.sv
// ----------------------------------------------------------------------------
// ptan_pkg: shared types and codes for the point table
// Table size, index width, command/status/direction codes and the
// request, response and engine control and status structures.
// ----------------------------------------------------------------------------
package ptan_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);
   localparam int REC_W      = 48;

   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_REMOVE   = 3'd1;
   localparam logic [2:0] CMD_POSITION = 3'd2;
   localparam logic [2:0] CMD_AT_POS   = 3'd3;
   localparam logic [2:0] CMD_NEAREST  = 3'd4;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_ID_EXISTS = 3'd1;
   localparam logic [2:0] STS_OCCUPIED  = 3'd2;
   localparam logic [2:0] STS_UNKNOWN   = 3'd3;
   localparam logic [2:0] STS_NONE_DIR  = 3'd4;
   localparam logic [2:0] STS_FULL      = 3'd5;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef struct packed {
      logic [2:0]         command;
      logic [15:0]        point_id;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic [1:0]         direction;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               found;
      logic [15:0]        result_id;
      logic signed [15:0] result_x;
      logic signed [15:0] result_y;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic slot_free;
   } eng_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_sts_type;

endpackage

### hdl/ptan_engine.sv
// ----------------------------------------------------------------------------
// ptan_engine: table memory and scan sequencer
// Holds the point records in a synchronous memory and the valid bits in
// flip-flops. Each command scans the table one entry per cycle; nearest
// scans twice when the point is found (locate the point, then search its row or column).
// ----------------------------------------------------------------------------
module ptan_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  ptan_pkg::eng_ctl_type ctl,
   input  ptan_pkg::req_type    req,
   output ptan_pkg::eng_sts_type sts,
   output ptan_pkg::rsp_type    rsp
);
   import ptan_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_FINISH
   } state_type;

   state_type          state_ff;
   req_type            cmd_ff;
   logic               pass2_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               cmp_on_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [REC_W-1:0]   rd_data_ff;
   logic [MAX_POINTS-1:0] valid_ff;

   logic               id_hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic signed [15:0] hit_x_ff;
   logic signed [15:0] hit_y_ff;
   logic               pos_hit_ff;
   logic [15:0]        pos_id_ff;
   logic               free_hit_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               near_hit_ff;
   logic [15:0]        best_d_ff;
   logic [15:0]        near_id_ff;

   logic [REC_W-1:0]   mem [MAX_POINTS];

   logic [15:0]        rec_id;
   logic signed [15:0] rec_x;
   logic signed [15:0] rec_y;
   logic [16:0]        dx_up, dx_dn, dy_up, dy_dn;
   logic               cand_in;
   logic [15:0]        cand_d_in;
   logic               fire;
   logic               add_ok;
   logic               wr_en_in;
   rsp_type            rsp_in;

   assign rec_id = rd_data_ff[47:32];
   assign rec_x  = rd_data_ff[31:16];
   assign rec_y  = rd_data_ff[15:0];

   // Differences are formed at 17 bits; the kept side is always positive
   // and below 2^16, so the low 16 bits are the distance.
   assign dx_up = {rec_x[15], rec_x} - {hit_x_ff[15], hit_x_ff};
   assign dx_dn = {hit_x_ff[15], hit_x_ff} - {rec_x[15], rec_x};
   assign dy_up = {rec_y[15], rec_y} - {hit_y_ff[15], hit_y_ff};
   assign dy_dn = {hit_y_ff[15], hit_y_ff} - {rec_y[15], rec_y};

   always_comb begin
      cand_in   = 1'b0;
      cand_d_in = 16'd0;
      unique case (cmd_ff.direction)
         DIR_NORTH: begin
            cand_in   = (rec_x == hit_x_ff) && (rec_y > hit_y_ff);
            cand_d_in = dy_up[15:0];
         end
         DIR_SOUTH: begin
            cand_in   = (rec_x == hit_x_ff) && (rec_y < hit_y_ff);
            cand_d_in = dy_dn[15:0];
         end
         DIR_EAST: begin
            cand_in   = (rec_y == hit_y_ff) && (rec_x > hit_x_ff);
            cand_d_in = dx_up[15:0];
         end
         DIR_WEST: begin
            cand_in   = (rec_y == hit_y_ff) && (rec_x < hit_x_ff);
            cand_d_in = dx_dn[15:0];
         end
         default: begin
            cand_in   = 1'b0;
            cand_d_in = 16'd0;
         end
      endcase
   end

   assign fire     = (state_ff == S_FINISH) && ctl.slot_free;
   assign add_ok   = !id_hit_ff && !pos_hit_ff && free_hit_ff;
   assign wr_en_in = fire && (cmd_ff.command == CMD_ADD) && add_ok;

   always_comb begin
      rsp_in = '0;
      unique case (cmd_ff.command)
         CMD_ADD: begin
            priority if (id_hit_ff)   rsp_in.status = STS_ID_EXISTS;
            else if (pos_hit_ff)      rsp_in.status = STS_OCCUPIED;
            else if (!free_hit_ff)    rsp_in.status = STS_FULL;
            else                      rsp_in.status = STS_OK;
         end
         CMD_REMOVE: begin
            rsp_in.status = id_hit_ff ? STS_OK : STS_UNKNOWN;
         end
         CMD_POSITION: begin
            if (id_hit_ff) begin
               rsp_in.result_x = hit_x_ff;
               rsp_in.result_y = hit_y_ff;
            end else begin
               rsp_in.status = STS_UNKNOWN;
            end
         end
         CMD_AT_POS: begin
            rsp_in.found     = pos_hit_ff;
            rsp_in.result_id = pos_hit_ff ? pos_id_ff : 16'd0;
         end
         CMD_NEAREST: begin
            priority if (!id_hit_ff)  rsp_in.status = STS_UNKNOWN;
            else if (!near_hit_ff)    rsp_in.status = STS_NONE_DIR;
            else                      rsp_in.result_id = near_id_ff;
         end
         default: rsp_in = '0;
      endcase
   end

   // Record memory: one write and one registered read per cycle. Writes only
   // happen at the end of a command, after its scan has finished reading.
   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         mem[free_idx_ff] <= {cmd_ff.point_id, cmd_ff.coord_x, cmd_ff.coord_y};
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         cmp_on_ff <= 1'b0;
         pass2_ff  <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         cmp_on_ff  <= (state_ff == S_SCAN);
         cmp_vld_ff <= valid_ff[rd_idx_ff];
         cmp_idx_ff <= rd_idx_ff;

         if (cmp_on_ff) begin
            if (!pass2_ff) begin
               if (cmp_vld_ff && (rec_id == cmd_ff.point_id)) begin
                  id_hit_ff  <= 1'b1;
                  hit_idx_ff <= cmp_idx_ff;
                  hit_x_ff   <= rec_x;
                  hit_y_ff   <= rec_y;
               end
               if (cmp_vld_ff && (rec_x == cmd_ff.coord_x) &&
                   (rec_y == cmd_ff.coord_y)) begin
                  pos_hit_ff <= 1'b1;
                  pos_id_ff  <= rec_id;
               end
               if (!cmp_vld_ff && !free_hit_ff) begin
                  free_hit_ff <= 1'b1;
                  free_idx_ff <= cmp_idx_ff;
               end
            end else if (cmp_vld_ff && cand_in &&
                         (!near_hit_ff || (cand_d_in < best_d_ff))) begin
               near_hit_ff <= 1'b1;
               best_d_ff   <= cand_d_in;
               near_id_ff  <= rec_id;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  cmd_ff      <= req;
                  pass2_ff    <= 1'b0;
                  rd_idx_ff   <= '0;
                  id_hit_ff   <= 1'b0;
                  pos_hit_ff  <= 1'b0;
                  free_hit_ff <= 1'b0;
                  near_hit_ff <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
               if (rd_idx_ff == LAST_IDX) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if ((cmd_ff.command == CMD_NEAREST) && !pass2_ff && id_hit_ff) begin
                  pass2_ff  <= 1'b1;
                  rd_idx_ff <= '0;
                  state_ff  <= S_SCAN;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (ctl.slot_free) begin
                  if (wr_en_in) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                  end
                  if ((cmd_ff.command == CMD_REMOVE) && id_hit_ff) begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = fire;
   assign rsp      = rsp_in;

endmodule

### hdl/point_table_axis_nearest.sv
// Throughput: one command at a time, set by the scan over the record memory's
// single read port at one entry per cycle (nearest scans twice if the point is found).
// Reset clears all valid bits at once; no clearing pass, the table starts empty.
// ----------------------------------------------------------------------------
// point_table_axis_nearest: bounded table of named points
// Accepts add, remove, position, at_position and nearest commands and
// returns one response beat per command through an output register.
// ----------------------------------------------------------------------------
module point_table_axis_nearest (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [15:0]        req_point_id,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic [1:0]         req_direction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic               rsp_found,
   output logic [15:0]        rsp_result_id,
   output logic signed [15:0] rsp_result_x,
   output logic signed [15:0] rsp_result_y
);
   import ptan_pkg::*;

   req_type     req;
   rsp_type     eng_rsp;
   eng_ctl_type eng_ctl;
   eng_sts_type eng_sts;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   assign req.command   = req_command;
   assign req.point_id  = req_point_id;
   assign req.coord_x   = req_coord_x;
   assign req.coord_y   = req_coord_y;
   assign req.direction = req_direction;

   assign req_ready         = eng_sts.idle;
   assign eng_ctl.start     = req_valid && eng_sts.idle;
   assign eng_ctl.slot_free = !rsp_valid_ff || rsp_ready;

   ptan_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctl   (eng_ctl),
      .req   (req),
      .sts   (eng_sts),
      .rsp   (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_sts.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_sts.done) begin
         rsp_ff <= eng_rsp;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_found     = rsp_ff.found;
   assign rsp_result_id = rsp_ff.result_id;
   assign rsp_result_x  = rsp_ff.result_x;
   assign rsp_result_y  = rsp_ff.result_y;

`ifndef SYNTHESIS
   // A finished command never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      eng_sts.done |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // Once a request beat is taken, the engine is busy scanning.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while engine busy");

   // Found is only ever reported with an ok status.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == STS_OK))
      else $error("found set with error status");

   // A new response is loaded only when the engine leaves its finish step.
   a_done_not_idle: assert property (@(posedge clock) disable iff (reset)
      eng_sts.done |=> eng_sts.idle)
      else $error("engine not idle after finishing");
`endif

endmodule
